[rtl/egbr_pkg.sv]
// ----------------------------------------------------------------------------
// egbr_pkg
// Shared types and constants of the Exp-Golomb bitstream reader.
// ----------------------------------------------------------------------------
package egbr_pkg;

  localparam logic [2:0] OP_RESTART = 3'd0;
  localparam logic [2:0] OP_APPEND  = 3'd1;
  localparam logic [2:0] OP_FIXED   = 3'd2;
  localparam logic [2:0] OP_UE      = 3'd3;
  localparam logic [2:0] OP_SE      = 3'd4;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned WIN_W  = 72;

  localparam logic [3:0] FIXED_BYTES = 4'd5;
  localparam logic [3:0] CODE_BYTES  = 4'd9;

  typedef struct packed {
    logic       done;
    logic       found;
    logic [4:0] lead;
  } scan_res_t;

  function automatic logic [2:0] lz8(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        n = 3'(7 - i);
      end
    end
    return n;
  endfunction

endpackage

[rtl/egbr_window.sv]
// ----------------------------------------------------------------------------
// egbr_window
// Collects fetched bytes, aligns them to the bit position and masks off
// every bit past the end of the written data.
// ----------------------------------------------------------------------------
module egbr_window (
  input  logic                          clk,
  input  logic                          shift_en,
  input  logic [7:0]                    byte_in,
  input  logic                          load,
  input  logic                          fixed_mode,
  input  logic [2:0]                    offset,
  input  logic [6:0]                    vcount,
  output logic [egbr_pkg::WORD_W-1:0]   word
);

  logic [egbr_pkg::WIN_W-1:0]  window;
  logic [egbr_pkg::WIN_W-1:0]  left;
  logic [egbr_pkg::WIN_W-1:0]  shifted;
  logic [egbr_pkg::WORD_W-1:0] mask;

  always_comb begin
    left    = fixed_mode ? {window[39:0], 32'd0} : window;
    shifted = left << offset;
    mask    = ~({egbr_pkg::WORD_W{1'b1}} >> vcount);
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      window <= {window[egbr_pkg::WIN_W-9:0], byte_in};
    end
    if (load) begin
      word <= shifted[egbr_pkg::WIN_W-1:8] & mask;
    end
  end

endmodule

[rtl/egbr_zscan.sv]
// ----------------------------------------------------------------------------
// egbr_zscan
// Leading zero scanner over a 32-bit word, one byte per cycle.
// ----------------------------------------------------------------------------
module egbr_zscan (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         bits,
  output egbr_pkg::scan_res_t res
);

  logic        busy;
  logic [31:0] sreg;
  logic [4:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      res  <= '0;
    end else begin
      if (start) begin
        busy     <= 1'b1;
        sreg     <= bits;
        acc      <= 5'd0;
        res.done <= 1'b0;
      end else if (busy) begin
        if (sreg[31:24] != 8'd0) begin
          busy      <= 1'b0;
          res.done  <= 1'b1;
          res.found <= 1'b1;
          res.lead  <= acc + {2'b00, egbr_pkg::lz8(sreg[31:24])};
        end else if (acc == 5'd24) begin
          busy      <= 1'b0;
          res.done  <= 1'b1;
          res.found <= 1'b0;
          res.lead  <= 5'd0;
        end else begin
          acc      <= acc + 5'd8;
          sreg     <= {sreg[23:0], 8'd0};
          res.done <= 1'b0;
        end
      end else begin
        res.done <= 1'b0;
      end
    end
  end

endmodule

[rtl/exp_golomb_bitstream_reader.sv]
// ----------------------------------------------------------------------------
// exp_golomb_bitstream_reader
// Byte buffer read MSB-first with fixed-width and Exp-Golomb reads.
// ----------------------------------------------------------------------------
// One item is in flight at a time, and every item returns exactly one result.
// Restart, append and unused op codes go from the idle state straight to the
// output state. Fixed and Exp-Golomb reads first fetch their bytes through the
// single byte-wide read port of the buffer memory, which fetches five bytes for
// a fixed read and nine for a code; a code then passes through the scanner that
// searches the prefix one byte per cycle. The buffer needs no clearing after
// reset, since only bytes already appended are read.
module exp_golomb_bitstream_reader #(
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_byte [7:0], bit_count [13:8]
  input  logic [2:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // value_unsigned, value_signed, remaining_bits,
                                 // byte_aligned, consumed_bytes
  output logic        m_tuser    // error
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned PW = CW + 3;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_FETCH   = 11'b00000000010,
    S_ALIGN   = 11'b00000000100,
    S_FIXED   = 11'b00000001000,
    S_SCAN_GO = 11'b00000010000,
    S_SCAN    = 11'b00000100000,
    S_SUFFIX  = 11'b00001000000,
    S_CODE    = 11'b00010000000,
    S_MAP     = 11'b00100000000,
    S_UPDATE  = 11'b01000000000,
    S_OUT     = 11'b10000000000
  } state_t;

  state_t state, state_next;

  logic [7:0]                  mem [BUFFER_BYTES];
  logic [7:0]                  rd_data;
  logic                        rd_en;
  logic                        rd_valid;
  logic [AW-1:0]               rd_addr;
  logic                        wr_en;
  logic [CW-1:0]               cnt;
  logic [PW-1:0]               bp;
  logic [PW-1:0]               avail;
  logic [6:0]                  vcount;
  logic                        accept;
  logic [2:0]                  op_q;
  logic [5:0]                  n_q;
  logic [3:0]                  issue_cnt;
  logic [3:0]                  fetch_n;
  logic [egbr_pkg::WORD_W-1:0] word;
  logic [egbr_pkg::WORD_W-1:0] word_sh;
  egbr_pkg::scan_res_t         scan_res;
  logic [4:0]                  lead_q;
  logic [31:0]                 sfx;
  logic [31:0]                 code;
  logic [31:0]                 vu;
  logic [31:0]                 vs_bits;
  logic                        err;
  logic [5:0]                  cons;
  logic                        short_sfx;
  logic [13:0]                 remaining;
  logic [10:0]                 consumed;

  assign s_tready  = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept    = s_tvalid && s_tready;
  assign wr_en     = accept && (s_tuser == egbr_pkg::OP_APPEND) &&
                     (cnt != CW'(BUFFER_BYTES));
  assign fetch_n   = (op_q == egbr_pkg::OP_FIXED) ? egbr_pkg::FIXED_BYTES
                                                  : egbr_pkg::CODE_BYTES;
  assign rd_en     = (state == S_FETCH) && (issue_cnt < fetch_n);
  assign rd_addr   = AW'(bp[PW-1:3] + CW'(issue_cnt));
  assign avail     = {cnt, 3'b000} - bp;
  assign vcount    = (avail >= PW'(64)) ? 7'd64 : avail[6:0];
  assign word_sh   = word << ({1'b0, lead_q} + 6'd1);
  assign short_sfx = avail < PW'({lead_q, 1'b1});
  assign remaining = 14'(avail);
  assign consumed  = 11'(bp[PW-1:3] + CW'(bp[2:0] != 3'd0));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt[AW-1:0]] <= s_tdata[7:0];
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  egbr_window u_window (
    .clk        (clk),
    .shift_en   (rd_valid),
    .byte_in    (rd_data),
    .load       (state == S_ALIGN),
    .fixed_mode (op_q == egbr_pkg::OP_FIXED),
    .offset     (bp[2:0]),
    .vcount     (vcount),
    .word       (word)
  );

  egbr_zscan u_zscan (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_SCAN_GO),
    .bits  (word[63:32]),
    .res   (scan_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (s_tuser inside {egbr_pkg::OP_FIXED, egbr_pkg::OP_UE, egbr_pkg::OP_SE}) begin
            state_next = S_FETCH;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_FETCH: begin
        if (issue_cnt == fetch_n && rd_valid) begin
          state_next = S_ALIGN;
        end
      end
      S_ALIGN: begin
        state_next = (op_q == egbr_pkg::OP_FIXED) ? S_FIXED : S_SCAN_GO;
      end
      S_FIXED:   state_next = S_UPDATE;
      S_SCAN_GO: state_next = S_SCAN;
      S_SCAN: begin
        if (scan_res.done) begin
          state_next = scan_res.found ? S_SUFFIX : S_UPDATE;
        end
      end
      S_SUFFIX:  state_next = short_sfx ? S_UPDATE : S_CODE;
      S_CODE:    state_next = S_MAP;
      S_MAP:     state_next = S_UPDATE;
      S_UPDATE:  state_next = S_OUT;
      S_OUT:     state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      bp       <= '0;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_en;
      if (state == S_OUT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (rd_en) begin
        issue_cnt <= issue_cnt + 4'd1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q      <= s_tuser;
            n_q       <= s_tdata[13:8];
            issue_cnt <= 4'd0;
            vu        <= 32'd0;
            vs_bits   <= 32'd0;
            err       <= 1'b0;
            cons      <= 6'd0;
            case (s_tuser)
              egbr_pkg::OP_RESTART: begin
                cnt <= '0;
                bp  <= '0;
              end
              egbr_pkg::OP_APPEND: begin
                if (wr_en) begin
                  cnt <= cnt + CW'(1);
                end else begin
                  err <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_FIXED: begin
          if (n_q > 6'd32 || PW'(n_q) > avail) begin
            err <= 1'b1;
          end else begin
            vu   <= word[63:32] >> (6'd32 - n_q);
            cons <= n_q;
          end
        end
        S_SCAN: begin
          if (scan_res.done) begin
            if (scan_res.found) begin
              lead_q <= scan_res.lead;
            end else if (avail != '0) begin
              err  <= 1'b1;
              cons <= (avail >= PW'(32)) ? 6'd32 : avail[5:0];
            end
          end
        end
        S_SUFFIX: begin
          if (short_sfx) begin
            err  <= 1'b1;
            cons <= {1'b0, lead_q} + 6'd1;
          end else begin
            sfx <= word_sh[63:32];
          end
        end
        S_CODE: begin
          code <= ((32'd1 << lead_q) - 32'd1) + (sfx >> (6'd32 - {1'b0, lead_q}));
          cons <= {lead_q, 1'b1};
        end
        S_MAP: begin
          if (op_q == egbr_pkg::OP_UE) begin
            vu <= code;
          end else if (code[0]) begin
            vs_bits <= {1'b0, code[31:1]} + 32'd1;
          end else begin
            vs_bits <= 32'd0 - {1'b0, code[31:1]};
          end
        end
        S_UPDATE: begin
          bp <= bp + PW'(cons);
        end
        S_OUT: begin
          m_tdata  <= {6'd0, consumed, (bp[2:0] == 3'd0), remaining, vs_bits, vu};
          m_tuser  <= err;
        end
        default: begin
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("Input taken while a result is stalled.");

  assert property (@(posedge clk) disable iff (rst)
    bp <= {cnt, 3'b000})
    else $error("Bit position ran past the written data.");

  assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(BUFFER_BYTES))
    else $error("Byte count exceeds the buffer size.");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> !m_tvalid)
    else $error("Result register loaded while still occupied.");

  assert property (@(posedge clk) disable iff (rst)
    scan_res.done |-> (state == S_SCAN))
    else $error("Prefix scan finished outside the scan state.");

endmodule

[dv/exp_golomb_bitstream_reader_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exp_golomb_bitstream_reader_tb
// Self-checking testbench for the Exp-Golomb bitstream reader. A table of
// directed items covers the empty buffer, the extremes and the error cases.
// Random phases of encoded codes and noise follow, with one pause that lets
// every pending result drain. Every result transaction is compared with the
// row's expected result, if its table row gives one, else with the output of a
// local model of the byte buffer and its bit position. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module exp_golomb_bitstream_reader_tb;

  localparam int unsigned BUF_BYTES    = 1024;
  localparam logic [2:0]  OP_UNUSED_LO = 3'd5;
  localparam logic [2:0]  OP_UNUSED_HI = 3'd7;
  localparam int          RANDOM_ITEMS = 600;
  localparam int          STALL_LIMIT  = 4000;

  typedef struct packed {
    logic [31:0] vu;
    logic [31:0] vs;
    logic        err;
    logic [13:0] rem;
    logic        aligned;
    logic [10:0] consumed;
  } read_result_t;

  typedef struct {
    logic [2:0]   op;
    logic [7:0]   data;
    logic [5:0]   cnt;
    bit           typed;
    read_result_t want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;
  logic        m_tuser;

  logic [7:0]   model_bytes [BUF_BYTES];
  int unsigned  model_pos;
  int unsigned  model_count;
  read_result_t pending_results [$];
  dir_row_t     dir_rows [$];
  int           fail_count;
  int           items_sent;
  int           stall_cycles;
  bit           no_idle;

  exp_golomb_bitstream_reader #(
    .BUFFER_BYTES(BUF_BYTES)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic fetch_bit(int unsigned pos);
    if ((pos >> 3) >= BUF_BYTES) begin
      return 1'b0;
    end
    return model_bytes[pos >> 3][7 - (pos & 7)];
  endfunction

  function automatic bit take_bits(int unsigned n, output logic [31:0] v);
    v = '0;
    if (n > 32) begin
      return 1'b0;
    end
    if (model_count * 8 - model_pos < n) begin
      return 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      v = {v[30:0], fetch_bit(model_pos)};
      model_pos++;
    end
    return 1'b1;
  endfunction

  function automatic bit take_code(output logic [31:0] v);
    int unsigned lead;
    logic [31:0] suffix;
    bit          found;
    lead   = 0;
    suffix = '0;
    found  = 1'b0;
    v      = '0;
    while (model_pos < model_count * 8) begin
      logic b;
      b = fetch_bit(model_pos);
      model_pos++;
      if (b) begin
        found = 1'b1;
        break;
      end
      lead++;
      if (lead > 31) begin
        return 1'b0;
      end
    end
    if (!found) begin
      return (lead == 0);
    end
    if (lead > 0 && !take_bits(lead, suffix)) begin
      return 1'b0;
    end
    v = ((32'd1 << lead) - 32'd1) + suffix;
    return 1'b1;
  endfunction

  function automatic read_result_t decode_item(logic [2:0] op, logic [7:0] data,
                                               logic [5:0] cnt);
    read_result_t r;
    logic [31:0]  code;
    r = '0;
    case (op)
      egbr_pkg::OP_RESTART: begin
        model_count = 0;
        model_pos   = 0;
      end
      egbr_pkg::OP_APPEND: begin
        if (model_count >= BUF_BYTES) begin
          r.err = 1'b1;
        end else begin
          model_bytes[model_count] = data;
          model_count++;
        end
      end
      egbr_pkg::OP_FIXED: begin
        if (!take_bits(cnt, r.vu)) begin
          r.err = 1'b1;
          r.vu  = '0;
        end
      end
      egbr_pkg::OP_UE: begin
        if (!take_code(r.vu)) begin
          r.err = 1'b1;
          r.vu  = '0;
        end
      end
      egbr_pkg::OP_SE: begin
        if (!take_code(code)) begin
          r.err = 1'b1;
        end else if (code[0]) begin
          r.vs = (code >> 1) + 32'd1;
        end else begin
          r.vs = 32'd0 - (code >> 1);
        end
      end
      default: begin
      end
    endcase
    r.rem      = 14'(model_count * 8 - model_pos);
    r.aligned  = (model_pos[2:0] == 3'd0);
    r.consumed = 11'((model_pos + 7) >> 3);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    read_result_t want;
    read_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.vu       = m_tdata[31:0];
      got.vs       = m_tdata[63:32];
      got.rem      = m_tdata[77:64];
      got.aligned  = m_tdata[78];
      got.consumed = m_tdata[89:79];
      got.err      = m_tuser;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result transaction", '0, got.vu);
      end else begin
        want = pending_results.pop_front();
        if (got.vu !== want.vu) report_mismatch("value_unsigned", want.vu, got.vu);
        if (got.vs !== want.vs) report_mismatch("value_signed", want.vs, got.vs);
        if (got.err !== want.err) begin
          report_mismatch("error", 32'(want.err), 32'(got.err));
        end
        if (got.rem !== want.rem) begin
          report_mismatch("remaining_bits", 32'(want.rem), 32'(got.rem));
        end
        if (got.aligned !== want.aligned) begin
          report_mismatch("byte_aligned", 32'(want.aligned), 32'(got.aligned));
        end
        if (got.consumed !== want.consumed) begin
          report_mismatch("consumed_bytes", 32'(want.consumed), 32'(got.consumed));
        end
        if (m_tdata[95:90] !== 6'd0) begin
          report_mismatch("tdata padding", '0, 32'(m_tdata[95:90]));
        end
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 24);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("exp_golomb_bitstream_reader regression: fail");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_item(logic [2:0] op, logic [7:0] data, logic [5:0] cnt,
                            bit typed = 1'b0, read_result_t want = '0);
    read_result_t predicted;
    while (!no_idle && $urandom_range(99) < 24) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, cnt, data};
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    predicted = decode_item(op, data, cnt);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(9);
    if (r < 3) return 8'h00;
    if (r < 6) return 8'($urandom_range(255) >> $urandom_range(7));
    return 8'($urandom_range(255));
  endfunction

  function automatic void add_row(logic [2:0] op, logic [7:0] data, logic [5:0] cnt,
                                  bit typed = 1'b0, read_result_t want = '0);
    dir_row_t row;
    row.op    = op;
    row.data  = data;
    row.cnt   = cnt;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  function automatic read_result_t res(logic [31:0] vu, logic err, logic [13:0] rem,
                                       logic aligned, logic [10:0] consumed);
    read_result_t r;
    r          = '0;
    r.vu       = vu;
    r.err      = err;
    r.rem      = rem;
    r.aligned  = aligned;
    r.consumed = consumed;
    return r;
  endfunction

  task automatic run_encoded_phase();
    bit          stream [$];
    logic [2:0]  kinds [$];
    int          counts [$];
    int          n_codes;
    int          lead;
    int          cnt;
    int          nb;
    int          r;
    logic [31:0] val;
    logic [7:0]  byte_v;
    issue_item(egbr_pkg::OP_RESTART, rand_byte(), 6'($urandom_range(63)));
    n_codes = $urandom_range(1, 6);
    for (int i = 0; i < n_codes; i++) begin
      r   = $urandom_range(9);
      val = $urandom;
      if (r < 3) begin
        cnt = ($urandom_range(7) == 0) ? 32 : $urandom_range(32);
        for (int j = cnt - 1; j >= 0; j--) stream.push_back(val[j]);
        kinds.push_back(egbr_pkg::OP_FIXED);
        counts.push_back(cnt);
      end else begin
        lead = ($urandom_range(9) == 0) ? $urandom_range(8, 31) : $urandom_range(5);
        for (int j = 0; j < lead; j++) stream.push_back(1'b0);
        stream.push_back(1'b1);
        for (int j = lead - 1; j >= 0; j--) stream.push_back(val[j]);
        kinds.push_back(r < 7 ? egbr_pkg::OP_UE : egbr_pkg::OP_SE);
        counts.push_back($urandom_range(63));
      end
    end
    while (stream.size() % 8 != 0) stream.push_back(1'($urandom_range(1)));
    nb = stream.size() / 8;
    if ($urandom_range(99) < 15) begin
      if ($urandom_range(1) == 0 && nb > 1) begin
        nb--;
      end else if (stream.size() != 0) begin
        r = $urandom_range(stream.size() - 1);
        stream[r] = !stream[r];
      end
    end
    for (int b = 0; b < nb; b++) begin
      for (int j = 0; j < 8; j++) byte_v[7 - j] = stream[b * 8 + j];
      issue_item(egbr_pkg::OP_APPEND, byte_v, 6'($urandom_range(63)));
    end
    for (int i = 0; i < n_codes; i++) begin
      issue_item(kinds[i], rand_byte(), 6'(counts[i]));
    end
    for (int i = $urandom_range(2); i > 0; i--) begin
      issue_item(3'($urandom_range(egbr_pkg::OP_FIXED, egbr_pkg::OP_SE)), rand_byte(),
                 6'($urandom_range(40)));
    end
  endtask

  task automatic run_noise_phase();
    logic [2:0] op;
    logic [5:0] cnt;
    for (int i = $urandom_range(4, 12); i > 0; i--) begin
      op  = ($urandom_range(2) == 0) ? egbr_pkg::OP_APPEND
                                     : 3'($urandom_range(egbr_pkg::OP_RESTART, OP_UNUSED_HI));
      cnt = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(33));
      issue_item(op, rand_byte(), cnt);
    end
  endtask

  initial begin
    bit drained;
    int phase;
    clk          = 1'b0;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = egbr_pkg::OP_RESTART;
    m_tready     = 1'b0;
    fail_count   = 0;
    items_sent   = 0;
    stall_cycles = 0;
    no_idle      = 1'b0;
    model_pos    = 0;
    model_count  = 0;
    drained      = 1'b0;
    phase        = 0;
    for (int i = 0; i < BUF_BYTES; i++) model_bytes[i] = '0;

    add_row(egbr_pkg::OP_FIXED, 8'h00, 6'd0, 1'b1, res('0, 1'b0, 14'd0, 1'b1, 11'd0));
    add_row(egbr_pkg::OP_UE, 8'h00, 6'd0, 1'b1, res('0, 1'b0, 14'd0, 1'b1, 11'd0));
    add_row(egbr_pkg::OP_SE, 8'h00, 6'd0, 1'b1, res('0, 1'b0, 14'd0, 1'b1, 11'd0));
    add_row(egbr_pkg::OP_FIXED, 8'h00, 6'd1, 1'b1, res('0, 1'b1, 14'd0, 1'b1, 11'd0));
    add_row(egbr_pkg::OP_FIXED, 8'hFF, 6'd63, 1'b1, res('0, 1'b1, 14'd0, 1'b1, 11'd0));
    add_row(OP_UNUSED_LO, 8'hFF, 6'd32, 1'b1, res('0, 1'b0, 14'd0, 1'b1, 11'd0));
    add_row(egbr_pkg::OP_APPEND, 8'hFF, 6'd0, 1'b1, res('0, 1'b0, 14'd8, 1'b1, 11'd0));
    add_row(egbr_pkg::OP_APPEND, 8'h00, 6'd63, 1'b1, res('0, 1'b0, 14'd16, 1'b1, 11'd0));
    add_row(egbr_pkg::OP_FIXED, 8'h00, 6'd33, 1'b1, res('0, 1'b1, 14'd16, 1'b1, 11'd0));
    add_row(egbr_pkg::OP_FIXED, 8'h00, 6'd8, 1'b1, res(32'hFF, 1'b0, 14'd8, 1'b1, 11'd1));
    add_row(egbr_pkg::OP_UE, 8'h00, 6'd0, 1'b1, res('0, 1'b1, 14'd0, 1'b1, 11'd2));
    add_row(egbr_pkg::OP_RESTART, 8'h00, 6'd0, 1'b1, res('0, 1'b0, 14'd0, 1'b1, 11'd0));
    add_row(egbr_pkg::OP_APPEND, 8'hA6, 6'd0);
    add_row(egbr_pkg::OP_UE, 8'h00, 6'd0);
    add_row(egbr_pkg::OP_SE, 8'h00, 6'd0);
    add_row(egbr_pkg::OP_SE, 8'h00, 6'd0);
    add_row(egbr_pkg::OP_APPEND, 8'h00, 6'd0);
    add_row(egbr_pkg::OP_APPEND, 8'h00, 6'd0);
    add_row(egbr_pkg::OP_APPEND, 8'h00, 6'd0);
    add_row(egbr_pkg::OP_APPEND, 8'h00, 6'd0);
    add_row(egbr_pkg::OP_UE, 8'h00, 6'd0);
    add_row(OP_UNUSED_HI, 8'h5A, 6'd21);
    add_row(egbr_pkg::OP_RESTART, 8'h00, 6'd0);
    add_row(egbr_pkg::OP_APPEND, 8'h08, 6'd0);
    add_row(egbr_pkg::OP_UE, 8'h00, 6'd0);

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      issue_item(dir_rows[i].op, dir_rows[i].data, dir_rows[i].cnt,
                 dir_rows[i].typed, dir_rows[i].want);
    end

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      phase++;
      no_idle = (phase >= 20 && phase < 35);
      if (!drained && items_sent >= RANDOM_ITEMS / 2) begin
        drain_results();
        drained = 1'b1;
      end else if ($urandom_range(9) < 7) begin
        run_encoded_phase();
      end else begin
        run_noise_phase();
      end
    end
    no_idle = 1'b0;

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("exp_golomb_bitstream_reader regression: pass");
    end else begin
      $display("exp_golomb_bitstream_reader regression: fail");
    end
    $finish;
  end

endmodule
